### rtl/msrf_pkg.sv
package msrf_pkg;

  // Position counter width; outputs carry its low word
  localparam int POSITION_BITS = 32;
  localparam int WORD_BITS     = 32;

  // Queue between classifier and output stage
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef logic [POSITION_BITS-1:0] pos_t;
  typedef logic [WORD_BITS-1:0]     word_t;

  // Character codes
  localparam logic [7:0] SYM_N_UP = 8'h4E;  // N
  localparam logic [7:0] SYM_N_LO = 8'h6E;  // n
  localparam logic [7:0] SYM_A_LO = 8'h61;  // a
  localparam logic [7:0] SYM_C_LO = 8'h63;  // c
  localparam logic [7:0] SYM_G_LO = 8'h67;  // g
  localparam logic [7:0] SYM_T_LO = 8'h74;  // t
  localparam logic [7:0] SYM_A_UP = 8'h41;  // A
  localparam logic [7:0] SYM_C_UP = 8'h43;  // C
  localparam logic [7:0] SYM_G_UP = 8'h47;  // G
  localparam logic [7:0] SYM_T_UP = 8'h54;  // T

  typedef enum logic [1:0] {
    KIND_GAP    = 2'd0,
    KIND_REPEAT = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    CLS_GAP,
    CLS_REPEAT,
    CLS_PLAIN,
    CLS_ERROR
  } sym_class_t;

  typedef struct packed {
    kind_t record_kind;
    word_t run_begin;
    word_t run_end;
    word_t run_length;
    word_t gap_number;
  } rec_t;

  // One queue word: the records caused by one character
  typedef struct packed {
    rec_t rec_a;
    rec_t rec_b;
    logic two_recs;
  } entry_t;

  // Sort a character into its class
  function automatic sym_class_t classify(input logic [7:0] sym);
    sym_class_t cls;
    case (sym) inside
      SYM_N_UP, SYM_N_LO:                     cls = CLS_GAP;
      SYM_A_LO, SYM_C_LO, SYM_G_LO, SYM_T_LO: cls = CLS_REPEAT;
      SYM_A_UP, SYM_C_UP, SYM_G_UP, SYM_T_UP: cls = CLS_PLAIN;
      default:                                cls = CLS_ERROR;
    endcase
    return cls;
  endfunction

  // Low word of a position, zero-extended when the counter is narrower
  function automatic word_t to_word(input pos_t p);
    logic [POSITION_BITS+WORD_BITS-1:0] wide;
    wide = {{WORD_BITS{1'b0}}, p};
    return wide[WORD_BITS-1:0];
  endfunction

  // Build an interval record
  function automatic rec_t make_rec(input kind_t k, input pos_t b, input pos_t e,
                                    input word_t num);
    rec_t r;
    r.record_kind = k;
    r.run_begin   = to_word(b);
    r.run_end     = to_word(e);
    r.run_length  = to_word(pos_t'(e - b));
    r.gap_number  = num;
    return r;
  endfunction

endpackage

### rtl/msrf_front.sv
module msrf_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            acc,
  input  logic [7:0]      symbol,
  input  logic            end_of_sequence,
  output logic            push,
  output msrf_pkg::entry_t entry
);
  import msrf_pkg::*;

  logic  gap_open_r, gap_open_nxt;
  logic  rep_open_r, rep_open_nxt;
  pos_t  gap_begin_r, gap_begin_nxt;
  pos_t  rep_begin_r, rep_begin_nxt;
  pos_t  position_r, position_nxt;
  word_t gaps_seen_r, gaps_seen_nxt;

  sym_class_t cls;
  pos_t       pos_inc;
  logic       gap_open_s, rep_open_s;
  pos_t       gap_begin_s, rep_begin_s;
  word_t      gaps_s;
  logic       close_v, flush_v;
  rec_t       close_rec, flush_rec, err_rec;

  // Classify and work out the records and next state
  always_comb begin
    cls         = classify(symbol);
    pos_inc     = position_r + pos_t'(1);
    gap_open_s  = gap_open_r;
    rep_open_s  = rep_open_r;
    gap_begin_s = gap_begin_r;
    rep_begin_s = rep_begin_r;
    gaps_s      = gaps_seen_r;
    close_v     = 1'b0;
    close_rec   = make_rec(KIND_REPEAT, rep_begin_r, position_r, '0);
    err_rec     = make_rec(KIND_ERROR, position_r, position_r, '0);
    err_rec.run_end    = '0;
    err_rec.run_length = '0;

    case (cls)
      CLS_GAP: begin
        close_v    = rep_open_r;
        rep_open_s = 1'b0;
        if (!gap_open_r) begin
          gaps_s      = gaps_seen_r + word_t'(1);
          gap_open_s  = 1'b1;
          gap_begin_s = position_r;
        end
      end
      CLS_REPEAT: begin
        close_v    = gap_open_r;
        close_rec  = make_rec(KIND_GAP, gap_begin_r, position_r, gaps_seen_r);
        gap_open_s = 1'b0;
        if (!rep_open_r) begin
          rep_open_s  = 1'b1;
          rep_begin_s = position_r;
        end
      end
      CLS_PLAIN: begin
        // at most one run is ever open
        close_v    = gap_open_r | rep_open_r;
        if (gap_open_r) begin
          close_rec = make_rec(KIND_GAP, gap_begin_r, position_r, gaps_seen_r);
        end
        gap_open_s = 1'b0;
        rep_open_s = 1'b0;
      end
      default: begin
      end
    endcase

    // Flush whichever run is still open on the last character
    flush_v = end_of_sequence & (gap_open_s | rep_open_s);
    if (gap_open_s) begin
      flush_rec = make_rec(KIND_GAP, gap_begin_s, pos_inc, gaps_s);
    end else begin
      flush_rec = make_rec(KIND_REPEAT, rep_begin_s, pos_inc, '0);
    end

    if (cls == CLS_ERROR) begin
      entry.rec_a    = err_rec;
      entry.rec_b    = err_rec;
      entry.two_recs = 1'b0;
      push           = acc;
    end else begin
      entry.rec_a    = close_v ? close_rec : flush_rec;
      entry.rec_b    = flush_rec;
      entry.two_recs = close_v & flush_v;
      push           = acc & (close_v | flush_v);
    end

    // Hold state on an unknown character or when no character is accepted
    gap_open_nxt  = gap_open_r;
    rep_open_nxt  = rep_open_r;
    gap_begin_nxt = gap_begin_r;
    rep_begin_nxt = rep_begin_r;
    position_nxt  = position_r;
    gaps_seen_nxt = gaps_seen_r;
    if (acc && cls != CLS_ERROR) begin
      gaps_seen_nxt = gaps_s;
      if (end_of_sequence) begin
        gap_open_nxt  = 1'b0;
        rep_open_nxt  = 1'b0;
        gap_begin_nxt = pos_t'(1);
        rep_begin_nxt = pos_t'(1);
        position_nxt  = '0;
      end else begin
        gap_open_nxt  = gap_open_s;
        rep_open_nxt  = rep_open_s;
        gap_begin_nxt = gap_begin_s;
        rep_begin_nxt = rep_begin_s;
        position_nxt  = pos_inc;
      end
    end
  end

  // Run state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_open_r  <= 1'b0;
      rep_open_r  <= 1'b0;
      gap_begin_r <= pos_t'(1);
      rep_begin_r <= pos_t'(1);
      position_r  <= '0;
      gaps_seen_r <= '0;
    end else begin
      gap_open_r  <= gap_open_nxt;
      rep_open_r  <= rep_open_nxt;
      gap_begin_r <= gap_begin_nxt;
      rep_begin_r <= rep_begin_nxt;
      position_r  <= position_nxt;
      gaps_seen_r <= gaps_seen_nxt;
    end
  end

endmodule

### rtl/msrf_queue.sv
module msrf_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  msrf_pkg::entry_t wr_entry,
  input  logic             pop,
  output msrf_pkg::entry_t head,
  output logic             not_empty,
  output logic             not_full
);
  import msrf_pkg::*;

  entry_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   count_r, count_nxt;

  assign head      = mem_r[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign not_full  = (count_r != Q_CNT_W'(Q_DEPTH));

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + Q_PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + Q_PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + Q_CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store words
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

endmodule

### rtl/msrf_back.sv
module msrf_back (
  input  logic             clk,
  input  logic             rst_n,
  input  msrf_pkg::entry_t head,
  input  logic             head_valid,
  output logic             pop,
  input  logic             out_ready,
  output logic             out_valid,
  output msrf_pkg::rec_t   out_rec,
  output logic             out_final
);
  import msrf_pkg::*;

  logic out_valid_r, out_valid_nxt;
  logic sel_r, sel_nxt;
  logic load;
  logic last_of_word;
  rec_t out_rec_r;
  logic out_final_r;

  assign load         = !out_valid_r || out_ready;
  assign last_of_word = sel_r || !head.two_recs;
  assign pop          = load && head_valid && last_of_word;

  // Step through the records of the head word
  always_comb begin
    out_valid_nxt = out_valid_r;
    sel_nxt       = sel_r;
    if (load) begin
      out_valid_nxt = head_valid;
      if (head_valid) begin
        sel_nxt = !last_of_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sel_r       <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sel_r       <= sel_nxt;
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      out_rec_r   <= sel_r ? head.rec_b : head.rec_a;
      out_final_r <= last_of_word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rec   = out_rec_r;
  assign out_final = out_final_r;

endmodule

### rtl/masked_sequence_run_finder_top.sv
// Masked sequence run finder. Takes one ASCII sequence character per word and
// reports closed runs as half-open [run_begin, run_end) intervals: gaps (N/n,
// with a gap number that keeps counting across sequences) and repeats
// (lowercase a/c/g/t); uppercase A/C/G/T close a run, in_end_of_sequence
// flushes an open run and returns the position to zero, and any other
// character gives an error record with no change of state. Input accepts one
// character per cycle while the queue has room; the classifier updates all
// run state per accepted character, and a two-word queue separates it from
// the output register. A character's records pass through the queue into
// the output register; one that closes a run and flushes another yields two
// records, and the output register drains at most one record per cycle while
// out_ready is high, so a stream of such characters fills the queue and drops
// in_ready. out_final_of_item marks the last record of each character.
module masked_sequence_run_finder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_symbol,
  input  logic        in_end_of_sequence,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_record_kind,
  output logic [31:0] out_run_begin,
  output logic [31:0] out_run_end,
  output logic [31:0] out_run_length,
  output logic [31:0] out_gap_number,
  output logic        out_final_of_item
);
  import msrf_pkg::*;

  logic   acc;
  logic   push;
  logic   pop;
  logic   q_not_empty;
  logic   q_not_full;
  entry_t wr_entry;
  entry_t head;
  rec_t   out_rec;

  assign in_ready = q_not_full;
  assign acc      = in_valid && q_not_full;

  msrf_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .acc             (acc),
    .symbol          (in_symbol),
    .end_of_sequence (in_end_of_sequence),
    .push            (push),
    .entry           (wr_entry)
  );

  msrf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_entry  (wr_entry),
    .pop       (pop),
    .head      (head),
    .not_empty (q_not_empty),
    .not_full  (q_not_full)
  );

  msrf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (q_not_empty),
    .pop        (pop),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .out_rec    (out_rec),
    .out_final  (out_final_of_item)
  );

  assign out_record_kind = out_rec.record_kind;
  assign out_run_begin   = out_rec.run_begin;
  assign out_run_end     = out_rec.run_end;
  assign out_run_length  = out_rec.run_length;
  assign out_gap_number  = out_rec.gap_number;

endmodule
